[rtl/core/spc_pkg.sv]
// Shared types, constants and command codes for the stereo peak compressor.
// Used by spc_cfg, spc_ctrl, spc_dp and stereo_peak_compressor.
package spc_pkg;

	// Sample width default and envelope coefficient fraction bits
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEFF_BITS      = 16;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 17;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_RATIO     = 3'd1,
		REG_ATTACK    = 3'd2,
		REG_RELEASE   = 3'd3,
		REG_MAKEUP    = 3'd4,
		REG_BLEND     = 3'd5,
		REG_BYPASS    = 3'd6
	} cfg_reg_t;

	// Level and gain constants
	localparam logic [13:0] DB_FLOOR        = 14'd15360;
	localparam logic [26:0] DB_PER_LOG2_Q16 = 27'd101008905;
	localparam logic [21:0] LOG2_10_Q32     = 22'd2786635;
	localparam logic [12:0] RATIO_MIN       = 13'd256;
	localparam logic [12:0] RATIO_MAX       = 13'd5120;
	localparam logic [15:0] MAKEUP_MIN      = 16'd4096;
	localparam logic [15:0] MAKEUP_MAX      = 16'd64917;
	localparam logic [16:0] BLEND_FULL      = 17'd65536;

	// Gain table: 2^(-2^-k) in Q30, k = 1..16, built by square roots after reset
	localparam int TAB_DEPTH = 16;
	localparam int TAB_BITS  = 30;
	localparam int ISQ_STEPS = 30;
	localparam int LOG_STEPS = 17;
	localparam int DIV_STEPS = 25;

	// Clamped configuration seen by the datapath
	typedef struct packed {
		logic [13:0] thr_mag;
		logic [12:0] ratio;
		logic [15:0] attack_coeff;
		logic [15:0] release_coeff;
		logic [15:0] makeup;
		logic [16:0] blend;
		logic        bypass;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_ISQ_LOAD,
		OP_ISQ_STEP,
		OP_LATCH,
		OP_ENV_MUL,
		OP_ENV_UPD,
		OP_NORM,
		OP_LOG,
		OP_DB,
		OP_GR,
		OP_EXP,
		OP_GAIN,
		OP_GSH,
		OP_WET1,
		OP_WET2,
		OP_MIX1,
		OP_MIX2,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_INIT_LOAD,
		ST_INIT_STEP,
		ST_IDLE,
		ST_START,
		ST_ENV,
		ST_NORM,
		ST_LOG,
		ST_DB,
		ST_GR,
		ST_EXP,
		ST_GAIN,
		ST_GSH,
		ST_WET1,
		ST_WET2,
		ST_MIX1,
		ST_MIX2,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t      op;
		logic [4:0]  idx;
		logic        last;
	} dp_cmd_t;

	typedef struct packed {
		logic byp;
		logic env_zero;
		logic norm_top;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/spc_cfg.sv]
// Configuration registers of the compressor with range clamping.
// Depends on spc_pkg.
module spc_cfg import spc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	logic [14:0] thr_q;
	logic [12:0] ratio_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [15:0] makeup_q;
	logic [16:0] blend_q;
	logic        bypass_q;

	// Write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			ratio_q   <= 13'd256;
			attack_q  <= 16'hFFFF;
			release_q <= 16'hFFFF;
			makeup_q  <= 16'd4096;
			blend_q   <= 17'd65536;
			bypass_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: thr_q     <= cfg_data[14:0];
				REG_RATIO:     ratio_q   <= cfg_data[12:0];
				REG_ATTACK:    attack_q  <= cfg_data[15:0];
				REG_RELEASE:   release_q <= cfg_data[15:0];
				REG_MAKEUP:    makeup_q  <= cfg_data[15:0];
				REG_BLEND:     blend_q   <= cfg_data[16:0];
				REG_BYPASS:    bypass_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] thr_neg;

	// Clamp to the legal ranges
	always_comb begin
		thr_neg = -$signed({thr_q[14], thr_q});
		if (thr_q[14] && (thr_neg > 16'sd15360)) begin
			cfg.thr_mag = DB_FLOOR;
		end else if (thr_q[14]) begin
			cfg.thr_mag = thr_neg[13:0];
		end else begin
			cfg.thr_mag = '0;
		end
		if (ratio_q < RATIO_MIN) begin
			cfg.ratio = RATIO_MIN;
		end else if (ratio_q > RATIO_MAX) begin
			cfg.ratio = RATIO_MAX;
		end else begin
			cfg.ratio = ratio_q;
		end
		if (makeup_q < MAKEUP_MIN) begin
			cfg.makeup = MAKEUP_MIN;
		end else if (makeup_q > MAKEUP_MAX) begin
			cfg.makeup = MAKEUP_MAX;
		end else begin
			cfg.makeup = makeup_q;
		end
		cfg.blend         = (blend_q > BLEND_FULL) ? BLEND_FULL : blend_q;
		cfg.attack_coeff  = attack_q;
		cfg.release_coeff = release_q;
		cfg.bypass        = bypass_q;
	end

endmodule

[rtl/core/spc_ctrl.sv]
// Sequencer of the compressor: table build after reset, then one sample at a time.
// Depends on spc_pkg; drives spc_dp through dp_cmd_t and reads dp_stat_t.
module spc_ctrl import spc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [3:0]  tk_q, tk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_LOAD;
			cnt_q   <= '0;
			tk_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			tk_q    <= tk_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		tk_d    = tk_q;
		unique case (state_q)
			ST_INIT_LOAD: begin
				state_d = ST_INIT_STEP;
				cnt_d   = '0;
			end
			ST_INIT_STEP: begin
				if (cnt_q == 5'(ISQ_STEPS - 1)) begin
					tk_d    = tk_q + 4'd1;
					state_d = (tk_q == 4'(TAB_DEPTH - 1)) ? ST_IDLE : ST_INIT_LOAD;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_IDLE:  if (in_valid) state_d = ST_START;
			ST_START: state_d = stat.byp ? ST_OUT : ST_ENV;
			ST_ENV:   state_d = ST_NORM;
			ST_NORM: begin
				cnt_d = '0;
				if (stat.env_zero) begin
					state_d = ST_DB;
				end else if (stat.norm_top) begin
					state_d = ST_LOG;
				end
			end
			ST_LOG: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(LOG_STEPS - 1)) state_d = ST_DB;
			end
			ST_DB:  state_d = ST_GR;
			ST_GR:  if (stat.div_done) state_d = ST_EXP;
			ST_EXP: begin
				state_d = ST_GAIN;
				cnt_d   = '0;
			end
			ST_GAIN: begin
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(TAB_DEPTH - 1)) state_d = ST_GSH;
			end
			ST_GSH:  state_d = ST_WET1;
			ST_WET1: state_d = ST_WET2;
			ST_WET2: state_d = ST_MIX1;
			ST_MIX1: state_d = ST_MIX2;
			ST_MIX2: state_d = ST_OUT;
			ST_OUT:  if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd.op   = OP_IDLE;
		cmd.idx  = cnt_q;
		cmd.last = 1'b0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_INIT_LOAD: cmd.op = OP_ISQ_LOAD;
			ST_INIT_STEP: begin
				cmd.op   = OP_ISQ_STEP;
				cmd.idx  = {1'b0, tk_q};
				cmd.last = (cnt_q == 5'(ISQ_STEPS - 1));
			end
			ST_IDLE:  cmd.op = in_valid ? OP_LATCH : OP_IDLE;
			ST_START: cmd.op = OP_ENV_MUL;
			ST_ENV:   cmd.op = OP_ENV_UPD;
			ST_NORM:  cmd.op = OP_NORM;
			ST_LOG:   cmd.op = OP_LOG;
			ST_DB:    cmd.op = OP_DB;
			ST_GR:    cmd.op = stat.div_done ? OP_GR : OP_IDLE;
			ST_EXP:   cmd.op = OP_EXP;
			ST_GAIN:  cmd.op = OP_GAIN;
			ST_GSH:   cmd.op = OP_GSH;
			ST_WET1:  cmd.op = OP_WET1;
			ST_WET2:  cmd.op = OP_WET2;
			ST_MIX1:  cmd.op = OP_MIX1;
			ST_MIX2:  cmd.op = OP_MIX2;
			ST_OUT:   cmd.op = stat.out_free ? OP_OUT : OP_IDLE;
			default:  cmd.op = OP_IDLE;
		endcase
	end

endmodule

[rtl/core/spc_dp.sv]
// Datapath of the compressor: envelopes, log2, ratio divider, gain table,
// gain product, mix and the output register. Depends on spc_pkg.
module spc_dp import spc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  cfg_t                   cfg,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic                   channel,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic [13:0]            gain_reduction
);

	localparam int SB  = SAMPLE_BITS;
	localparam int LZW = $clog2(SB);
	localparam int NLW = LZW + 16;
	localparam int DBW = NLW + 27;
	localparam logic [SB+16:0] ENV_RND = (SB+17)'(1) << (COEFF_BITS - 1);
	localparam logic [SB+5:0]  POS_LIM = (SB+6)'((64'd1 << (SB - 1)) - 64'd1);
	localparam logic [SB+5:0]  NEG_LIM = (SB+6)'(64'd1 << (SB - 1));

	// Sample and item registers
	logic [SB-1:0]   raw_q, ax_q;
	logic            neg_q, chan_q, byp_q, up_q, zero_q;
	logic [SB-1:0]   env_q [2];
	logic [13:0]     meter_q;
	logic [SB+15:0]  estep_q;
	logic [SB-1:0]   m_q;
	logic [LZW-1:0]  lz_q;
	logic [31:0]     sq_q;
	logic [15:0]     frac_q;
	logic [DBW-1:0]  db_q;
	logic [30:0]     grp_q;
	logic [35:0]     ep_q;
	logic [30:0]     g_q;
	logic [SB+30:0]  wp_q;
	logic [SB+15:0]  mp_q;
	logic [SB+4:0]   wm2_q;
	logic [SB+21:0]  mix_q;
	logic            out_valid_q;
	logic [SB-1:0]   out_q;
	logic [13:0]     gr_out_q;

	// Divider for the ratio factor
	logic [24:0]     dnum_q;
	logic [13:0]     drem_q;
	logic [16:0]     dquo_q;
	logic [4:0]      dcnt_q;

	// Square root unit and gain table
	logic [59:0]     v_q, res_q, bit_q;
	logic [TAB_BITS-1:0] tprev_q;
	logic [TAB_BITS-1:0] tab_q [TAB_DEPTH];

	// Combinational terms
	logic [SB-1:0]   sin_mag, env_cur, dlt, estep, env_new;
	logic [SB+16:0]  ernd;
	logic [15:0]     coeff;
	logic            up;
	logic [SB+30:0]  mwide;
	logic [30:0]     malign, mn;
	logic [61:0]     msq;
	logic            lbit;
	logic [NLW-1:0]  negl;
	logic [DBW:0]    dbsum;
	logic [DBW-32:0] dbr;
	logic [13:0]     ldb, over, gr;
	logic [16:0]     ff;
	logic [31:0]     grsum;
	logic [36:0]     esum;
	logic [20:0]     ee;
	logic            gbit;
	logic [61:0]     gprod;
	logic [SB+31:0]  wsum;
	logic [SB-1:0]   wm;
	logic [SB+16:0]  msum;
	logic [SB+5:0]   om, omc;
	logic [59:0]     isq_t, isq_res;
	logic            isq_ge;
	logic [13:0]     dtrial;
	logic            dge;
	logic            out_take;

	always_comb begin
		sin_mag = sample_in[SB-1] ? (~sample_in + SB'(1)) : sample_in;
		env_cur = env_q[chan_q];
		up      = (ax_q > env_cur);
		dlt     = up ? (ax_q - env_cur) : (env_cur - ax_q);
		coeff   = up ? cfg.attack_coeff : cfg.release_coeff;
		ernd    = {1'b0, estep_q} + ENV_RND;
		estep   = SB'(ernd >> COEFF_BITS);
		env_new = up_q ? (env_cur + estep) : (env_cur - estep);

		// Align the normalized envelope to a Q30 mantissa
		mwide   = {m_q, 31'b0};
		malign  = mwide[SB+30:SB];
		lbit    = sq_q[31];
		mn      = lbit ? sq_q[31:1] : sq_q[30:0];
		msq     = mn * mn;

		negl    = (lz_q == '0) ? '0 : ({lz_q, 16'b0} - NLW'(frac_q));
		dbsum   = {1'b0, db_q} + (DBW+1)'(64'd1 << 31);
		dbr     = dbsum[DBW:32];
		if (zero_q || (dbr > (DBW-31)'(DB_FLOOR))) begin
			ldb = DB_FLOOR;
		end else begin
			ldb = dbr[13:0];
		end
		over    = (ldb < cfg.thr_mag) ? (cfg.thr_mag - ldb) : '0;
		ff      = 17'(18'd65536 - {1'b0, dquo_q});

		grsum   = {1'b0, grp_q} + 32'd32768;
		gr      = grsum[29:16];
		esum    = {1'b0, ep_q} + 37'd32768;
		ee      = esum[36:16];
		gbit    = ee[4'd15 - cmd.idx[3:0]];
		gprod   = (g_q * tab_q[cmd.idx[3:0]]) + 62'(64'd1 << 29);

		wsum    = {1'b0, wp_q} + (SB+32)'(64'd1 << 29);
		wm      = wsum[SB+29:30];
		msum    = {1'b0, mp_q} + (SB+17)'(2048);

		om      = mix_q[SB+21:16];
		if (neg_q) begin
			omc = (om > NEG_LIM) ? NEG_LIM : om;
		end else begin
			omc = (om > POS_LIM) ? POS_LIM : om;
		end

		isq_t   = res_q + bit_q;
		isq_ge  = (v_q >= isq_t);
		isq_res = isq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

		dtrial  = {drem_q[12:0], dnum_q[24]};
		dge     = (dtrial >= {1'b0, cfg.ratio});

		out_take = out_valid_q && !out_stall;
	end

	// Control state: envelopes, meter, table build, divider count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q[0]    <= '0;
			env_q[1]    <= '0;
			meter_q     <= '0;
			tprev_q     <= TAB_BITS'(64'd1 << 29);
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_ENV_UPD) env_q[chan_q] <= env_new;
			if (cmd.op == OP_EXP) meter_q <= gr;
			if ((cmd.op == OP_ISQ_STEP) && cmd.last) tprev_q <= isq_res[TAB_BITS-1:0];
			if (cmd.op == OP_ENV_MUL) begin
				dcnt_q <= 5'(DIV_STEPS);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 5'd1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, advanced by command
	always_ff @(posedge clk) begin
		// Ratio divider, one quotient bit per cycle
		if (cmd.op == OP_ENV_MUL) begin
			dnum_q <= 25'(26'd16777216 + {13'b0, cfg.ratio[12:1]});
			drem_q <= '0;
			dquo_q <= '0;
		end else if (dcnt_q != '0) begin
			drem_q <= dge ? (dtrial - {1'b0, cfg.ratio}) : dtrial;
			dquo_q <= {dquo_q[15:0], dge};
			dnum_q <= {dnum_q[23:0], 1'b0};
		end

		case (cmd.op)
			OP_ISQ_LOAD: begin
				v_q   <= {tprev_q, 30'b0};
				res_q <= '0;
				bit_q <= 60'(64'd1 << 58);
			end
			OP_ISQ_STEP: begin
				if (isq_ge) v_q <= v_q - isq_t;
				res_q <= isq_res;
				bit_q <= bit_q >> 2;
				if (cmd.last) tab_q[cmd.idx[3:0]] <= isq_res[TAB_BITS-1:0];
			end
			OP_LATCH: begin
				raw_q  <= sample_in;
				ax_q   <= sin_mag;
				neg_q  <= sample_in[SB-1];
				chan_q <= channel;
				byp_q  <= cfg.bypass;
			end
			OP_ENV_MUL: begin
				estep_q <= coeff * dlt;
				up_q    <= up;
			end
			OP_ENV_UPD: begin
				m_q    <= env_new;
				lz_q   <= '0;
				zero_q <= (env_new == '0);
			end
			OP_NORM: begin
				// Shift up to the leading one, four places when the top nibble is clear
				if (m_q[SB-1]) begin
					sq_q <= {1'b0, malign};
				end else if (m_q[SB-1 -: 4] == 4'd0) begin
					m_q  <= m_q << 4;
					lz_q <= lz_q + LZW'(4);
				end else begin
					m_q  <= m_q << 1;
					lz_q <= lz_q + LZW'(1);
				end
			end
			OP_LOG: begin
				sq_q   <= msq[61:30];
				frac_q <= {frac_q[14:0], lbit};
			end
			OP_DB:   db_q  <= negl * DB_PER_LOG2_Q16;
			OP_GR:   grp_q <= over * ff;
			OP_EXP: begin
				ep_q <= gr * LOG2_10_Q32;
				g_q  <= 31'(64'd1 << 30);
			end
			OP_GAIN: if (gbit) g_q <= gprod[60:30];
			OP_GSH:  g_q <= (ee[20:16] >= 5'd31) ? '0 : (g_q >> ee[20:16]);
			OP_WET1: wp_q <= ax_q * g_q;
			OP_WET2: mp_q <= wm * cfg.makeup;
			OP_MIX1: begin
				wm2_q <= msum[SB+16:12];
				mix_q <= (SB+22)'(ax_q * (18'd65536 - {1'b0, cfg.blend}));
			end
			OP_MIX2: mix_q <= mix_q + (SB+22)'(wm2_q * cfg.blend) + (SB+22)'(32768);
			OP_OUT: begin
				gr_out_q <= meter_q;
				if (byp_q) begin
					out_q <= raw_q;
				end else if (neg_q) begin
					out_q <= ~omc[SB-1:0] + SB'(1);
				end else begin
					out_q <= omc[SB-1:0];
				end
			end
			default: ;
		endcase
	end

	assign stat.byp      = byp_q;
	assign stat.env_zero = zero_q;
	assign stat.norm_top = m_q[SB-1];
	assign stat.div_done = (dcnt_q == '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign sample_out     = out_q;
	assign gain_reduction = gr_out_q;

endmodule

[rtl/core/stereo_peak_compressor.sv]
// Channel    | beat moves                     | handshake
// input      | sample_in, channel             | in_valid / in_stall
// output     | sample_out, gain_reduction     | out_valid / out_stall
// config     | cfg_index, cfg_data            | cfg_write (no wait)
//
// After reset a square-root unit builds the 16 gain table entries while in_stall
// stays high. Config writes are taken. A compressed sample offers its result
// beat after the 25-step ratio divider, overrun only when the leading-one search
// and the 17-step log2 loop run long on a small envelope, then the 16-step gain
// loop, the gain shift and four multiply steps. A bypassed sample goes from the
// start state straight to the output state.
// A held result stalls the next sample only at its end.
// Top level of the compressor; depends on spc_pkg, spc_cfg, spc_ctrl, spc_dp.
module stereo_peak_compressor import spc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SAMPLE_BITS-1:0]   sample_in,
	input  logic                     channel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [SAMPLE_BITS-1:0]   sample_out,
	output logic [13:0]              gain_reduction,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	spc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	spc_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg),
		.sample_in      (sample_in),
		.channel        (channel),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_out     (sample_out),
		.gain_reduction (gain_reduction)
	);

endmodule

[sim/stereo_peak_compressor_chk.sv]
// Checker for the stereo peak compressor: watches the config, input and output
// channels, predicts each result beat and compares it. Depends on spc_pkg.
module stereo_peak_compressor_chk import spc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [SAMPLE_BITS-1:0]   sample_in,
	input  logic                     channel,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [SAMPLE_BITS-1:0]   sample_out,
	input  logic [13:0]              gain_reduction,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       pending,
	output int                       errors
);

	localparam logic [63:0] SMASK = (64'd1 << SAMPLE_BITS) - 64'd1;

	typedef struct {
		logic [SAMPLE_BITS-1:0] sample;
		logic [13:0]            gr;
	} comp_result_t;

	comp_result_t result_q[$];

	// shadow registers and state
	int          thr;
	logic [12:0] ratio_r;
	logic [15:0] attack_r, release_r, makeup_r;
	logic [16:0] blend_r;
	logic        bypass_r;
	logic [63:0] env_l, env_r;
	logic [13:0] meter;

	logic [63:0] root_tab[1:16];

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q30 for the gain product
	initial begin
		logic [63:0] t;
		t = int_sqrt(64'd1 << 59);
		for (int k = 1; k <= 16; k++) begin
			root_tab[k] = t;
			t = int_sqrt(t << 30);
		end
	end

	// envelope level as a dB magnitude in 1/256 dB
	function automatic logic [31:0] env_to_db(logic [63:0] env);
		int p;
		logic [63:0] m, frac, negl, db;
		if (env == 0) return 32'(DB_FLOOR);
		p = 0;
		frac = 0;
		for (int k = 0; k < 63; k++) if (env[k]) p = k;
		m = (p <= 30) ? (env << (30 - p)) : (env >> (p - 30));
		for (int k = 1; k <= 16; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				frac |= 64'd1 << (16 - k);
				m >>= 1;
			end
		end
		negl = (64'(SAMPLE_BITS - 1 - p) << 16) - frac;
		if ($signed(negl) <= 0) return 0;
		db = (negl * 64'(DB_PER_LOG2_Q16) + (64'd1 << 31)) >> 32;
		return (db > 64'(DB_FLOOR)) ? 32'(DB_FLOOR) : 32'(db);
	endfunction

	// linear gain 10^(-gr/5120) in Q30
	function automatic logic [63:0] gr_to_gain(logic [31:0] gr);
		logic [63:0] e, n, fr, g;
		e = (64'(gr) * 64'(LOG2_10_Q32) + 64'd32768) >> 16;
		n = e >> 16;
		fr = e & 64'hFFFF;
		g = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if (fr[16-k]) g = (g * root_tab[k] + (64'd1 << 29)) >> 30;
		if (n >= 31) return 0;
		return g >> n;
	endfunction

	// compute one compressed beat and advance the channel envelope
	function automatic comp_result_t compress(logic [SAMPLE_BITS-1:0] x, logic ch);
		comp_result_t r;
		logic        neg;
		logic [63:0] raw, ax, env, d, step, f, g, wm, om, lim;
		int          level, th;
		logic [31:0] gr, rt, mk, b;
		raw = 64'(x);
		neg = x[SAMPLE_BITS-1];
		ax = neg ? ((SMASK - raw) + 1) : raw;
		if (bypass_r) begin
			r.sample = x;
			r.gr = meter;
			return r;
		end
		env = ch ? env_r : env_l;
		if (ax > env) begin
			d = ax - env;
			step = (64'(attack_r) * d + (64'd1 << (COEFF_BITS - 1))) >> COEFF_BITS;
			env += step;
		end else begin
			d = env - ax;
			step = (64'(release_r) * d + (64'd1 << (COEFF_BITS - 1))) >> COEFF_BITS;
			env -= step;
		end
		env &= SMASK;
		if (ch) env_r = env;
		else env_l = env;

		level = -int'(env_to_db(env));
		th = (thr < -15360) ? -15360 : ((thr > 0) ? 0 : thr);
		rt = (ratio_r < RATIO_MIN) ? 32'(RATIO_MIN) :
			((ratio_r > RATIO_MAX) ? 32'(RATIO_MAX) : 32'(ratio_r));
		gr = 0;
		if (level > th) begin
			f = 64'd65536 - ((64'd1 << 24) + 64'(rt / 2)) / 64'(rt);
			gr = 32'((64'(level - th) * f + 64'd32768) >> 16);
		end
		meter = gr[13:0];

		g = gr_to_gain(gr);
		mk = (makeup_r < MAKEUP_MIN) ? 32'(MAKEUP_MIN) :
			((makeup_r > MAKEUP_MAX) ? 32'(MAKEUP_MAX) : 32'(makeup_r));
		b = (blend_r > BLEND_FULL) ? 32'(BLEND_FULL) : 32'(blend_r);
		wm = (ax * g + (64'd1 << 29)) >> 30;
		wm = (wm * 64'(mk) + 64'd2048) >> 12;
		om = (ax * 64'(65536 - b) + wm * 64'(b) + 64'd32768) >> 16;
		lim = neg ? (64'd1 << (SAMPLE_BITS - 1)) : ((64'd1 << (SAMPLE_BITS - 1)) - 1);
		if (om > lim) om = lim;
		r.sample = neg ? SAMPLE_BITS'((~om + 1) & SMASK) : SAMPLE_BITS'(om);
		r.gr = meter;
		return r;
	endfunction

	assign pending = result_q.size();

	// track config writes, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		comp_result_t want;
		logic [14:0]  t15;
		if (!arst_n) begin
			thr = 0;
			ratio_r = RATIO_MIN;
			attack_r = 16'hFFFF;
			release_r = 16'hFFFF;
			makeup_r = MAKEUP_MIN;
			blend_r = BLEND_FULL;
			bypass_r = 1'b0;
			env_l = 0;
			env_r = 0;
			meter = 0;
			errors = 0;
			result_q.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_THRESHOLD: begin
						t15 = cfg_data[14:0];
						thr = int'($signed(t15));
					end
					REG_RATIO:   ratio_r = cfg_data[12:0];
					REG_ATTACK:  attack_r = cfg_data[15:0];
					REG_RELEASE: release_r = cfg_data[15:0];
					REG_MAKEUP:  makeup_r = cfg_data[15:0];
					REG_BLEND:   blend_r = cfg_data[16:0];
					REG_BYPASS:  bypass_r = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result beat: sample_out %0d gain_reduction %0d",
						$signed(sample_out), gain_reduction);
					errors = errors + 1;
				end else begin
					want = result_q.pop_front();
					if (sample_out !== want.sample) begin
						$error("sample_out expected %0d actual %0d",
							$signed(want.sample), $signed(sample_out));
						errors = errors + 1;
					end
					if (gain_reduction !== want.gr) begin
						$error("gain_reduction expected %0d actual %0d",
							want.gr, gain_reduction);
						errors = errors + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(compress(sample_in, channel));
		end
	end

endmodule

[sim/stereo_peak_compressor_tb.sv]
// Testbench top for the stereo peak compressor: clock, reset, stimulus and
// verdict. Depends on spc_pkg, stereo_peak_compressor and its checker.
module stereo_peak_compressor_tb;
	import spc_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int LIMIT = 3000000;
	localparam int HOLD_CYCLES = 400;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [SB-1:0]            sample_in = '0;
	logic                     channel = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [SB-1:0]            sample_out;
	logic [13:0]              gain_reduction;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       pending, errors;
	int                       cycles = 0;
	bit                       calm = 0;
	bit                       hold_req = 0;
	int                       loud_l = 20, loud_r = 20;

	always #6 clk = ~clk;

	stereo_peak_compressor u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .channel(channel),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .gain_reduction(gain_reduction),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	stereo_peak_compressor_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .channel(channel),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .gain_reduction(gain_reduction),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .errors(errors)
	);

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("stereo_peak_compressor_tb: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request, none when calm
	initial begin
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
				@(posedge clk);
			end else if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// sometimes idle for a random burst (never when calm), then offer one beat and hold it until taken
	task automatic send_beat(logic [SB-1:0] s, logic ch);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		channel <= ch;
		do @(posedge clk); while (in_stall);
	endtask

	// drain the block, then one register write
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic load_setting(int th, int ra, int at, int rl, int mk, int bl, int by);
		write_reg(REG_THRESHOLD, th & 16'h7FFF);
		write_reg(REG_RATIO, ra);
		write_reg(REG_ATTACK, at);
		write_reg(REG_RELEASE, rl);
		write_reg(REG_MAKEUP, mk);
		write_reg(REG_BLEND, bl);
		write_reg(REG_BYPASS, by);
	endtask

	// programs of loud and quiet passages, plus noise, silence and full-scale beats
	function automatic logic [SB-1:0] pick_sample(logic ch);
		int lvl, mag;
		lvl = ch ? loud_r : loud_l;
		if ($urandom_range(0, 29) == 0) begin
			lvl = $urandom_range(0, 23);
			if (ch) loud_r = lvl;
			else loud_l = lvl;
		end
		case ($urandom_range(0, 9))
			0: return SB'($urandom);
			1: return '0;
			2: return $urandom_range(0, 1) ? SB'(-8388608) : SB'(8388607);
			default: begin
				mag = (lvl == 0) ? $urandom_range(0, 1) : $urandom_range(0, (1 << lvl) - 1);
				return $urandom_range(0, 1) ? SB'(-mag) : SB'(mag);
			end
		endcase
	endfunction

	task automatic random_run(int count);
		logic ch;
		for (int i = 0; i < count; i++) begin
			ch = 1'($urandom_range(0, 1));
			send_beat(pick_sample(ch), ch);
		end
	endtask

	initial begin
		logic [SB-1:0] edge_vals[8];
		edge_vals = '{SB'(-8388608), SB'(8388607), SB'(0), SB'(1), SB'(-1), 24'h400000,
			24'hC00000, 24'h000100};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes on both channels, reset settings
		for (int i = 0; i < 8; i++) send_beat(edge_vals[i], i[0]);
		load_setting(-6144, 1024, 20000, 3000, 8192, 65536, 0);
		for (int i = 0; i < 8; i++) send_beat(edge_vals[i], ~i[0]);
		// bypass holds envelopes and meter
		write_reg(REG_BYPASS, 1);
		for (int i = 0; i < 4; i++) send_beat(edge_vals[i], i[0]);
		write_reg(REG_UNUSED, 131071);
		write_reg(REG_BYPASS, 0);
		send_beat(edge_vals[0], 1'b0);
		send_beat(edge_vals[3], 1'b1);

		// random phases over a range of settings, clamps and extremes included
		load_setting(-15360, 5120, 65535, 65535, 64917, 65536, 0);
		random_run(150);
		hold_req = 1;
		random_run(60);
		load_setting(-3000, 640, 0, 65535, 4096, 0, 0);
		random_run(120);
		load_setting(100, 0, 500, 30, 0, 131071, 0);
		random_run(120);
		load_setting(-16384, 8191, 65535, 0, 65535, 32768, 0);
		random_run(120);
		load_setting(-9000, 2000, 4000, 200, 20000, 49152, 1);
		random_run(80);
		load_setting(-12000, 3000, 8000, 800, 30000, 65536, 0);
		random_run(200);
		// pause the sender until everything has come back
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		load_setting(-2000, 512, 30000, 1000, 6000, 20000, 0);
		random_run(100);
		calm = 1;
		random_run(150);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("stereo_peak_compressor_tb: PASS");
		else
			$display("stereo_peak_compressor_tb: FAIL");
		$finish;
	end

endmodule
